### rtl/ght_pkg.sv
`default_nettype none

package ght_pkg;

    localparam int SLOT_COUNT_DEF = 128;
    localparam int SCAN_CHUNK     = 16;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 8;
    localparam int GEN_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_LOOKUP   = 2'd1,
        CMD_FREE     = 2'd2,
        CMD_FREE_ALL = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic sweep_step;
        logic commit;
    } t_dp_ctrl;

    typedef struct packed {
        logic scan_found;
        logic scan_last;
        logic sweep_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/ght_if.sv
`default_nettype none

interface ght_req_if import ght_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   handle_index;
    logic [GEN_W-1:0]   handle_generation;
    logic [SIZE_W-1:0]  alloc_width;
    logic [SIZE_W-1:0]  alloc_height;

    modport source (
        output valid, cmd, handle_index, handle_generation, alloc_width, alloc_height,
        input  ready
    );
    modport sink (
        input  valid, cmd, handle_index, handle_generation, alloc_width, alloc_height,
        output ready
    );
endinterface

interface ght_rsp_if import ght_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    out_index;
    logic [GEN_W-1:0]    out_generation;
    logic [SIZE_W-1:0]   slot_width;
    logic [SIZE_W-1:0]   slot_height;

    modport source (
        output valid, status, out_index, out_generation, slot_width, slot_height,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_generation, slot_width, slot_height,
        output ready
    );
endinterface

`default_nettype wire

### rtl/generational_handle_table_unit.sv
// Channel   Dir  Port    Contents of one word
// request   in   i_req   cmd, handle_index, handle_generation, alloc_width, alloc_height
// response  out  o_rsp   status, out_index, out_generation, slot_width, slot_height
//
// Lookup and free go through a read state and an execute state to the response word.
// Allocate scans the occupancy bits in groups of 16 slots until it finds a free one,
// then reads that slot's memory and executes; a full table skips the memory read.
// Free-all sweeps the generation memory one slot a cycle.
// Reset clears occupancy and the per-slot generation valid bits at once; no clearing pass runs.
// One request is in work at a time; a finished word waiting in the output register
// does not stop the next request from being accepted.
`default_nettype none

module generational_handle_table_unit import ght_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ght_req_if.sink     i_req,
    ght_rsp_if.source   o_rsp
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    logic     w_in_ready;

    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_cmd   (t_cmd'(i_req.cmd)),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_ctrl     (w_ctrl)
    );

    ght_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (w_ctrl),
        .o_stat              (w_stat),
        .i_cmd               (i_req.cmd),
        .i_handle_index      (i_req.handle_index),
        .i_handle_generation (i_req.handle_generation),
        .i_alloc_width       (i_req.alloc_width),
        .i_alloc_height      (i_req.alloc_height),
        .i_out_ready         (o_rsp.ready),
        .o_out_valid         (o_rsp.valid),
        .o_status            (o_rsp.status),
        .o_out_index         (o_rsp.out_index),
        .o_out_generation    (o_rsp.out_generation),
        .o_slot_width        (o_rsp.slot_width),
        .o_slot_height       (o_rsp.slot_height)
    );

    assign i_req.ready = w_in_ready;

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.commit |-> w_stat.out_free)
        else $error("Result committed while the output register was occupied.");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.commit |=> o_rsp.valid)
        else $error("Committed result did not appear on the response channel.");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.scan_step || w_ctrl.sweep_step) |-> !i_req.ready)
        else $error("Request channel ready while a request is in work.");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctrl.capture, w_ctrl.scan_step, w_ctrl.sweep_step, w_ctrl.commit}))
        else $error("Controller issued more than one datapath command in a cycle.");

endmodule

`default_nettype wire

### rtl/ght_ram.sv
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/ght_ctrl.sv
`default_nettype none

module ght_ctrl import ght_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_READ  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_EXEC  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    case (i_in_cmd)
                        CMD_ALLOC:    n_state = S_SCAN;
                        CMD_LOOKUP:   n_state = S_READ;
                        CMD_FREE:     n_state = S_READ;
                        CMD_FREE_ALL: n_state = S_SWEEP;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_found) begin
                    n_state = S_READ;
                end else if (i_stat.scan_last) begin
                    n_state = S_EXEC;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_SWEEP: begin
                o_ctrl.sweep_step = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_ctrl.commit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

### rtl/ght_dp.sv
`default_nettype none

module ght_dp import ght_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctrl            i_ctrl,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [IDX_W-1:0]    i_handle_index,
    input  logic [GEN_W-1:0]    i_handle_generation,
    input  logic [SIZE_W-1:0]   i_alloc_width,
    input  logic [SIZE_W-1:0]   i_alloc_height,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_out_index,
    output logic [GEN_W-1:0]    o_out_generation,
    output logic [SIZE_W-1:0]   o_slot_width,
    output logic [SIZE_W-1:0]   o_slot_height
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int NCH    = (SLOT_COUNT + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PAD_W  = NCH * SCAN_CHUNK;
    localparam int OFF_W  = $clog2(SCAN_CHUNK);
    localparam int SWP_W  = $clog2(SLOT_COUNT + 1);
    localparam int SZ_W   = 2 * SIZE_W;

    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_gen_ok;
    t_cmd                  r_cmd;
    logic [GEN_W-1:0]      r_gen;
    logic [SIZE_W-1:0]     r_w;
    logic [SIZE_W-1:0]     r_h;
    logic                  r_idx_ok;
    logic [SLOT_W-1:0]     r_slot;
    logic [CH_W-1:0]       r_chunk;
    logic                  r_full;
    logic [SWP_W-1:0]      r_sweep;
    logic                  r_sw_wr;
    logic [SLOT_W-1:0]     r_sw_addr;
    logic                  r_gv_q;

    logic                  r_o_valid;
    t_status               r_o_status;
    logic [IDX_W-1:0]      r_o_index;
    logic [GEN_W-1:0]      r_o_gen;
    logic [SIZE_W-1:0]     r_o_w;
    logic [SIZE_W-1:0]     r_o_h;

    logic [PAD_W-1:0]      w_pad;
    logic [SCAN_CHUNK-1:0] w_chunk;
    logic                  w_found;
    logic [OFF_W-1:0]      w_off;
    logic [CH_W+OFF_W-1:0] w_slot_full;
    logic                  w_last;
    logic [IDX_W-1:0]      w_idx_m1;
    logic                  w_idx_ok;
    logic [SLOT_W-1:0]     w_sw_rd;
    logic [SLOT_W-1:0]     w_rd_addr;
    logic [GEN_W-1:0]      w_gen_q;
    logic [SZ_W-1:0]       w_sz_q;
    logic [GEN_W-1:0]      w_gen_rd;
    logic [GEN_W-1:0]      w_gen_inc;
    logic [GEN_W-1:0]      w_gen_fix;
    logic [GEN_W-1:0]      w_alloc_gen;
    logic                  w_hit;
    logic                  w_out_free;
    logic                  w_gen_we;
    logic [SLOT_W-1:0]     w_gen_waddr;
    logic [GEN_W-1:0]      w_gen_wdata;
    logic                  w_sz_we;

    // Slots beyond the table read as occupied so the scan never picks them.
    always_comb begin
        w_pad                 = '1;
        w_pad[SLOT_COUNT-1:0] = r_used;
    end

    assign w_chunk = w_pad[r_chunk * SCAN_CHUNK +: SCAN_CHUNK];

    always_comb begin
        w_found = 1'b0;
        w_off   = '0;
        for (int k = SCAN_CHUNK - 1; k >= 0; k--) begin
            if (!w_chunk[k]) begin
                w_found = 1'b1;
                w_off   = OFF_W'(k);
            end
        end
    end

    assign w_slot_full = {r_chunk, w_off};
    assign w_last      = (r_chunk == CH_W'(NCH - 1));

    assign w_idx_m1 = i_handle_index - IDX_W'(1);
    assign w_idx_ok = (i_handle_index != '0) && (i_handle_index <= IDX_W'(SLOT_COUNT));

    assign w_sw_rd   = (r_sweep < SWP_W'(SLOT_COUNT)) ? r_sweep[SLOT_W-1:0] : '0;
    assign w_rd_addr = i_ctrl.sweep_step ? w_sw_rd : r_slot;

    // A generation entry never written since reset reads as one.
    assign w_gen_rd    = r_gv_q ? w_gen_q : GEN_W'(1);
    assign w_gen_inc   = w_gen_rd + GEN_W'(1);
    assign w_gen_fix   = (w_gen_inc == '0) ? GEN_W'(1) : w_gen_inc;
    assign w_alloc_gen = (w_gen_rd == '0) ? GEN_W'(1) : w_gen_rd;
    assign w_hit       = r_idx_ok && r_used[r_slot] && (w_gen_rd == r_gen);
    assign w_out_free  = !r_o_valid || i_out_ready;

    always_comb begin
        w_gen_we    = 1'b0;
        w_gen_waddr = r_slot;
        w_gen_wdata = w_gen_rd;
        w_sz_we     = 1'b0;
        if (i_ctrl.sweep_step && r_sw_wr && r_used[r_sw_addr]) begin
            w_gen_we    = 1'b1;
            w_gen_waddr = r_sw_addr;
            w_gen_wdata = w_gen_inc;
        end
        if (i_ctrl.commit) begin
            case (r_cmd)
                CMD_ALLOC: begin
                    if (!r_full) begin
                        w_gen_we    = 1'b1;
                        w_gen_wdata = w_alloc_gen;
                        w_sz_we     = 1'b1;
                    end
                end
                CMD_FREE: begin
                    if (w_hit) begin
                        w_gen_we    = 1'b1;
                        w_gen_wdata = w_gen_fix;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    ght_ram #(
        .WIDTH (GEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (w_gen_we),
        .i_waddr (w_gen_waddr),
        .i_wdata (w_gen_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_gen_q)
    );

    ght_ram #(
        .WIDTH (SZ_W),
        .DEPTH (SLOT_COUNT)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_sz_we),
        .i_waddr (r_slot),
        .i_wdata ({r_w, r_h}),
        .i_raddr (w_rd_addr),
        .o_rdata (w_sz_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_gen_ok  <= '0;
            r_chunk   <= '0;
            r_full    <= 1'b0;
            r_sweep   <= '0;
            r_sw_wr   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_gen_we) begin
                r_gen_ok[w_gen_waddr] <= 1'b1;
            end
            if (i_ctrl.capture) begin
                r_chunk <= '0;
                r_full  <= 1'b0;
                r_sweep <= '0;
                r_sw_wr <= 1'b0;
            end
            if (i_ctrl.scan_step && !w_found) begin
                if (w_last) begin
                    r_full <= 1'b1;
                end else begin
                    r_chunk <= r_chunk + CH_W'(1);
                end
            end
            if (i_ctrl.sweep_step) begin
                r_sweep <= r_sweep + SWP_W'(1);
                r_sw_wr <= (r_sweep < SWP_W'(SLOT_COUNT));
            end
            if (i_ctrl.commit) begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (!r_full) begin
                            r_used[r_slot] <= 1'b1;
                        end
                    end
                    CMD_FREE: begin
                        if (w_hit) begin
                            r_used[r_slot] <= 1'b0;
                        end
                    end
                    CMD_FREE_ALL: begin
                        r_used <= '0;
                    end
                    default: begin
                    end
                endcase
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gv_q <= r_gen_ok[w_rd_addr];
        if (i_ctrl.capture) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_gen    <= i_handle_generation;
            r_w      <= i_alloc_width;
            r_h      <= i_alloc_height;
            r_idx_ok <= w_idx_ok;
            r_slot   <= w_idx_ok ? w_idx_m1[SLOT_W-1:0] : '0;
        end
        if (i_ctrl.scan_step && w_found) begin
            r_slot <= w_slot_full[SLOT_W-1:0];
        end
        if (i_ctrl.sweep_step) begin
            r_sw_addr <= w_sw_rd;
        end
        if (i_ctrl.commit) begin
            r_o_status <= ST_OK;
            r_o_index  <= '0;
            r_o_gen    <= '0;
            r_o_w      <= '0;
            r_o_h      <= '0;
            case (r_cmd)
                CMD_ALLOC: begin
                    if (r_full) begin
                        r_o_status <= ST_FULL;
                    end else begin
                        r_o_index <= IDX_W'(r_slot) + IDX_W'(1);
                        r_o_gen   <= w_alloc_gen;
                    end
                end
                CMD_LOOKUP: begin
                    if (w_hit) begin
                        r_o_w <= w_sz_q[SZ_W-1:SIZE_W];
                        r_o_h <= w_sz_q[SIZE_W-1:0];
                    end else begin
                        r_o_status <= ST_INVALID;
                    end
                end
                CMD_FREE: begin
                    if (!w_hit) begin
                        r_o_status <= ST_INVALID;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.scan_found = w_found;
    assign o_stat.scan_last  = w_last;
    assign o_stat.sweep_done = (r_sweep == SWP_W'(SLOT_COUNT));
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_out_index      = r_o_index;
    assign o_out_generation = r_o_gen;
    assign o_slot_width     = r_o_w;
    assign o_slot_height    = r_o_h;

endmodule

`default_nettype wire

### tb/sv/ght_table_checker.sv
`timescale 1ns / 1ps

module ght_table_checker import ght_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ght_req_if   i_req,
    ght_rsp_if   i_rsp,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   index;
        logic [GEN_W-1:0]   generation;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_reply;

    logic               slot_busy [SLOT_COUNT];
    logic [GEN_W-1:0]   slot_gen  [SLOT_COUNT];
    logic [SIZE_W-1:0]  slot_w    [SLOT_COUNT];
    logic [SIZE_W-1:0]  slot_h    [SLOT_COUNT];

    t_reply replies_due[$];
    int     mismatches = 0;

    task automatic clear_slots();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i] = 1'b0;
            slot_gen[i]  = 1;
            slot_w[i]    = '0;
            slot_h[i]    = '0;
        end
    endtask

    function automatic int find_slot(input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] g);
        int s;
        if (idx == 0 || int'(idx) > SLOT_COUNT) begin
            return -1;
        end
        s = int'(idx) - 1;
        if (!slot_busy[s] || slot_gen[s] != g) begin
            return -1;
        end
        return s;
    endfunction

    task automatic predict_reply(input t_cmd c, input logic [IDX_W-1:0] idx,
                                 input logic [GEN_W-1:0] g, input logic [SIZE_W-1:0] w,
                                 input logic [SIZE_W-1:0] h);
        t_reply r;
        int     s;
        bit     found;
        r     = '{ST_OK, '0, '0, '0, '0};
        found = 1'b0;
        case (c)
            CMD_ALLOC: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!found && !slot_busy[i]) begin
                        found        = 1'b1;
                        slot_busy[i] = 1'b1;
                        slot_w[i]    = w;
                        slot_h[i]    = h;
                        if (slot_gen[i] == 0) begin
                            slot_gen[i] = 1;
                        end
                        r.index      = IDX_W'(i + 1);
                        r.generation = slot_gen[i];
                    end
                end
                if (!found) begin
                    r.status = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                s = find_slot(idx, g);
                if (s < 0) begin
                    r.status = ST_INVALID;
                end else begin
                    r.width  = slot_w[s];
                    r.height = slot_h[s];
                end
            end
            CMD_FREE: begin
                s = find_slot(idx, g);
                if (s < 0) begin
                    r.status = ST_INVALID;
                end else begin
                    slot_busy[s] = 1'b0;
                    slot_w[s]    = '0;
                    slot_h[s]    = '0;
                    slot_gen[s]  = slot_gen[s] + 1;
                    if (slot_gen[s] == 0) begin
                        slot_gen[s] = 1;
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_busy[i]) begin
                        slot_busy[i] = 1'b0;
                        slot_w[i]    = '0;
                        slot_h[i]    = '0;
                        slot_gen[i]  = slot_gen[i] + 1;
                    end
                end
            end
        endcase
        replies_due.push_back(r);
    endtask

    task automatic check_reply();
        t_reply want;
        t_reply got;
        got = '{t_status'(i_rsp.status), i_rsp.out_index, i_rsp.out_generation,
                i_rsp.slot_width, i_rsp.slot_height};
        if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected reply word status=%0d index=%0d gen=%0d size=%0dx%0d",
                         $realtime, got.status, got.index, got.generation, got.width,
                         got.height);
            end
            return;
        end
        want = replies_due.pop_front();
        if (got.status !== want.status || got.index !== want.index
                || got.generation !== want.generation || got.width !== want.width
                || got.height !== want.height) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: reply word expected status=%0d index=%0d gen=%0d size=%0dx%0d",
                         $realtime, want.status, want.index, want.generation, want.width,
                         want.height);
                $display("%0t: reply word actual   status=%0d index=%0d gen=%0d size=%0dx%0d",
                         $realtime, got.status, got.index, got.generation, got.width,
                         got.height);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_slots();
            replies_due.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                check_reply();
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                predict_reply(t_cmd'(i_req.cmd), i_req.handle_index, i_req.handle_generation,
                              i_req.alloc_width, i_req.alloc_height);
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/sv/generational_handle_table_unit_tb.sv
`timescale 1ns / 1ps

module generational_handle_table_unit_tb import ght_pkg::*;;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int WORD_TARGET = 1050;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] generation;
    } t_handle;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   pending;
    int   fail_count;
    int   words_sent = 0;
    int   burst_left = 0;
    int   stall_mode = 0;
    int   stall_cycles = 0;

    t_handle live_handles[$];

    ght_req_if req_if();
    ght_rsp_if rsp_if();

    generational_handle_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ght_table_checker #(.SLOT_COUNT(SLOTS)) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles == 0) begin
            stall_mode   <= $urandom_range(0, 3);
            stall_cycles <= $urandom_range(16, 128);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= cycle_count[3];
        endcase
    end

    // Handles handed out by the block feed the lookup and free traffic.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1
                && rsp_if.status == ST_OK && rsp_if.out_index != 0) begin
            live_handles.push_back('{rsp_if.out_index, rsp_if.out_generation});
        end
    end

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SIZE_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input t_cmd c, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] g, input logic [SIZE_W-1:0] w,
                             input logic [SIZE_W-1:0] h);
        int gap;
        req_if.valid             <= 1'b1;
        req_if.cmd               <= c;
        req_if.handle_index      <= idx;
        req_if.handle_generation <= g;
        req_if.alloc_width       <= w;
        req_if.alloc_height      <= h;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        words_sent++;
        if (c == CMD_FREE_ALL) begin
            live_handles.delete();
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_if.valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_alloc();
        send_word(CMD_ALLOC, IDX_W'($urandom), $urandom, pick_size(), pick_size());
    endtask

    task automatic send_handle_op(input t_cmd c);
        t_handle          hnd;
        int               pos;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] g;
        bit               genuine;
        genuine = 1'b0;
        if (live_handles.size() != 0 && $urandom_range(0, 5) != 0) begin
            pos     = $urandom_range(0, live_handles.size() - 1);
            hnd     = live_handles[pos];
            idx     = hnd.index;
            g       = hnd.generation;
            genuine = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    g       = g ^ (32'd1 << $urandom_range(0, 31));
                    genuine = 1'b0;
                end
                1: begin
                    g       = g - 1;
                    genuine = 1'b0;
                end
                2: begin
                    idx     = IDX_W'($urandom);
                    genuine = 1'b0;
                end
                default: ;
            endcase
            if (genuine && c == CMD_FREE) begin
                live_handles.delete(pos);
            end
        end else begin
            idx = IDX_W'($urandom_range(0, 255));
            g   = ($urandom_range(0, 1) == 0) ? GEN_W'($urandom_range(0, 4)) : GEN_W'($urandom);
        end
        send_word(c, idx, g, SIZE_W'($urandom), SIZE_W'($urandom));
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_mix(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_alloc();
            end else if (pick < 60) begin
                send_handle_op(CMD_LOOKUP);
            end else if (pick < 88) begin
                send_handle_op(CMD_FREE);
            end else if (pick < 91) begin
                send_word(CMD_FREE_ALL, IDX_W'($urandom), $urandom, SIZE_W'($urandom),
                          SIZE_W'($urandom));
            end else begin
                send_word(t_cmd'($urandom_range(0, 3)), IDX_W'($urandom), $urandom,
                          SIZE_W'($urandom), SIZE_W'($urandom));
            end
        end
    endtask

    initial begin
        bit drained_mid;
        int kind;
        drained_mid               = 1'b0;
        i_rst_n                  <= 1'b0;
        req_if.valid             <= 1'b0;
        req_if.cmd               <= CMD_ALLOC;
        req_if.handle_index      <= '0;
        req_if.handle_generation <= '0;
        req_if.alloc_width       <= '0;
        req_if.alloc_height      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_ALLOC, 8'd0, 32'd0, 16'h0000, 16'h0000);
        send_word(CMD_ALLOC, 8'hff, 32'hffffffff, 16'hffff, 16'hffff);
        send_alloc();
        send_word(CMD_LOOKUP, 8'd1, 32'd1, 16'hffff, 16'hffff);
        send_word(CMD_LOOKUP, 8'd2, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, 8'd0, 32'd0, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, IDX_W'(SLOTS + 1), 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, 8'hff, 32'hffffffff, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, 8'd4, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, 8'd1, 32'd2, 16'h0000, 16'h0000);
        send_word(CMD_FREE, 8'd1, 32'd2, 16'h0000, 16'h0000);
        send_word(CMD_FREE, 8'd1, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_FREE, 8'd1, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, 8'd1, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_ALLOC, 8'd0, 32'd0, 16'h1234, 16'h8001);
        send_word(CMD_LOOKUP, 8'd1, 32'd2, 16'h0000, 16'h0000);
        send_word(CMD_FREE, 8'd0, 32'd0, 16'h0000, 16'h0000);
        send_word(CMD_FREE, 8'd200, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_FREE_ALL, 8'd0, 32'd0, 16'h0000, 16'h0000);
        send_word(CMD_LOOKUP, 8'd2, 32'd1, 16'h0000, 16'h0000);
        send_word(CMD_FREE_ALL, 8'hff, 32'hffffffff, 16'hffff, 16'hffff);
        send_word(CMD_ALLOC, 8'd0, 32'd0, 16'h00ff, 16'hff00);
        send_word(CMD_LOOKUP, 8'd1, 32'd3, 16'h0000, 16'h0000);
        drain();

        while (words_sent < WORD_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                repeat (SLOTS + 2) send_alloc();
                repeat ($urandom_range(2, 10)) send_handle_op(CMD_LOOKUP);
                if ($urandom_range(0, 1) == 0) begin
                    send_word(CMD_FREE_ALL, IDX_W'($urandom), $urandom, SIZE_W'($urandom),
                              SIZE_W'($urandom));
                end
            end else if (kind == 2) begin
                send_word(CMD_FREE_ALL, IDX_W'($urandom), $urandom, SIZE_W'($urandom),
                          SIZE_W'($urandom));
            end else begin
                run_mix(20);
            end
            if (!drained_mid && words_sent >= WORD_TARGET / 2) begin
                drained_mid = 1'b1;
                drain();
            end
        end

        drain();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/ght_pkg.sv
rtl/ght_if.sv
rtl/ght_ram.sv
rtl/ght_ctrl.sv
rtl/ght_dp.sv
rtl/generational_handle_table_unit.sv
tb/sv/ght_table_checker.sv
tb/sv/generational_handle_table_unit_tb.sv
